@@ design/gncd_pkg.sv @@
// ----------------------------------------------------------------------------
// gncd_pkg
// Shared types, constants and helper functions for the grid nearest centre
// distance block.
// ----------------------------------------------------------------------------
package gncd_pkg;

    // Fixed field widths.
    localparam int POS_BITS        = 16;
    localparam int CELL_W          = 7;
    localparam int CS_W            = 17;
    localparam int CTR_W           = CELL_W + CS_W + 1;
    localparam int SQ_W            = 2 * CTR_W;
    localparam int DIST_W          = 34;
    localparam int GD_W            = 2 * CELL_W + 1;
    localparam int ENTRY_W         = 2 * CELL_W;
    localparam int IN_TDATA_W      = 48;
    localparam int OUT_TDATA_W     = 40;
    localparam int MAX_GRID_CELLS  = 65;
    localparam int MAX_CENTRES_DEF = 256;

    // Operation codes.
    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;

    // One decoded command.
    typedef struct packed {
        logic [1:0]          opcode;
        logic [POS_BITS-1:0] pos_x;
        logic [POS_BITS-1:0] pos_y;
        logic [CELL_W-1:0]   centre_x;
        logic [CELL_W-1:0]   centre_y;
    } cmd_t;

    // Configuration register set.
    typedef struct packed {
        logic              grid_kind;
        logic [CELL_W-1:0] grid_cells;
        logic [CS_W-1:0]   cell_size;
    } cfg_t;

    // Effective grid size: zero counts as one, large values are clamped.
    function automatic logic [CELL_W-1:0] eff_cells(input logic [CELL_W-1:0] g);
        logic [CELL_W-1:0] r;
        r = g;
        if (g == '0)
            r = CELL_W'(1);
        else if (g > CELL_W'(MAX_GRID_CELLS))
            r = CELL_W'(MAX_GRID_CELLS);
        return r;
    endfunction

    // Grid cell of a position, clamped to the last cell.
    function automatic logic [CELL_W-1:0] cell_of(input logic [POS_BITS-1:0] pos,
                                                  input logic [CELL_W-1:0]   g);
        logic [POS_BITS+CELL_W-1:0] prod;
        logic [CELL_W-1:0]          c;
        prod = (POS_BITS+CELL_W)'(pos) * (POS_BITS+CELL_W)'(g);
        c    = prod[POS_BITS+CELL_W-1:POS_BITS];
        if (c > g - CELL_W'(1))
            c = g - CELL_W'(1);
        return c;
    endfunction

endpackage

@@ design/gncd_ram.sv @@
// ----------------------------------------------------------------------------
// gncd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gncd_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/gncd_front.sv @@
// ----------------------------------------------------------------------------
// gncd_front
// Input side: unpacks incoming items, drops the unused opcode and pushes the
// rest into the command queue.
// ----------------------------------------------------------------------------
module gncd_front
    import gncd_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    // Unpack the item fields from the low bits upward.
    always_comb
    begin
        q_cmd.opcode   = s_tdata[1:0];
        q_cmd.pos_x    = s_tdata[2+POS_BITS-1:2];
        q_cmd.pos_y    = s_tdata[2+2*POS_BITS-1:2+POS_BITS];
        q_cmd.centre_x = s_tdata[2+2*POS_BITS+CELL_W-1:2+2*POS_BITS];
        q_cmd.centre_y = s_tdata[2+2*POS_BITS+2*CELL_W-1:2+2*POS_BITS+CELL_W];
    end

    // An unused opcode is accepted and discarded here.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && (q_cmd.opcode != OP_NONE);

endmodule

@@ design/gncd_queue.sv @@
// ----------------------------------------------------------------------------
// gncd_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module gncd_queue
    import gncd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/gncd_back.sv @@
// ----------------------------------------------------------------------------
// gncd_back
// Execution side: runs loads and clears on the centre table, and evaluates
// queries through a four-stage distance pipeline fed one centre per cycle.
// ----------------------------------------------------------------------------
module gncd_back
    import gncd_pkg::*;
#(
    parameter int MAX_CENTRES = MAX_CENTRES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_empty,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DIST_W-1:0] out_dist,
    output logic [1:0]        out_status
);

    localparam int CW = $clog2(MAX_CENTRES + 1);
    localparam int AW = $clog2(MAX_CENTRES);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CENTRES);
    localparam logic [SQ_W:0] SAT     = (SQ_W+1)'({DIST_W{1'b1}});

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CELL = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]        state_reg, state_next;
    cmd_t              cmd_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [CELL_W-1:0] qx_reg, qy_reg;
    logic              p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic              p1_valid_next;
    logic              found_reg, found_next;
    logic [GD_W-1:0]   best_gd_reg, best_gd_next;
    logic [DIST_W-1:0] best_pd_reg, best_pd_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;
    logic [1:0]        out_status_reg, out_status_next;

    logic              wr_en;
    logic [ENTRY_W-1:0] rd_data;
    logic [CELL_W-1:0] g_eff;

    // Pipeline data registers.
    logic [CTR_W-1:0]  p2_ctr_x_reg, p2_ctr_y_reg;
    logic [CELL_W-1:0] p2_gx_reg, p2_gy_reg;
    logic [CTR_W-1:0]  p3_dx_reg, p3_dy_reg;
    logic [GD_W-1:0]   p3_gd_reg;
    logic [SQ_W-1:0]   p4_sx_reg, p4_sy_reg;
    logic [GD_W-1:0]   p4_gd_reg;

    logic [CELL_W-1:0] src_x, src_y;
    logic [CTR_W-1:0]  px_ext, py_ext;
    logic [SQ_W:0]     sum_sq;
    logic [DIST_W-1:0] pd;

    assign g_eff = eff_cells(cfg.grid_cells);

    gncd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CENTRES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({q_cmd.centre_y, q_cmd.centre_x}),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Distance of the current pipeline head, saturated.
    assign sum_sq = (SQ_W+1)'(p4_sx_reg) + (SQ_W+1)'(p4_sy_reg);
    assign pd     = (sum_sq > SAT) ? {DIST_W{1'b1}} : sum_sq[DIST_W-1:0];

    // Control sequencer.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        len_next        = len_reg;
        p1_valid_next   = 1'b0;
        found_next      = found_reg;
        best_gd_next    = best_gd_reg;
        best_pd_next    = best_pd_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_dist_next   = out_dist_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.opcode)
                        OP_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            out_dist_next  = '0;
                            if (count_reg >= CNT_MAX)
                            begin
                                out_status_next = ST_DROP;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                count_next      = count_reg + CW'(1);
                                out_status_next = ST_OK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_QUERY:
                        begin
                            state_next = S_CELL;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CELL:
            begin
                if (cfg.grid_kind && (count_reg == '0))
                begin
                    out_valid_next  = 1'b1;
                    out_dist_next   = '0;
                    out_status_next = ST_EMPTY;
                    state_next      = S_IDLE;
                end
                else
                begin
                    len_next   = cfg.grid_kind ? count_reg : CW'(1);
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg < len_reg)
                begin
                    p1_valid_next = 1'b1;
                    idx_next      = idx_reg + CW'(1);
                end
                // Keep the least grid distance, then the least point distance.
                if (p4_valid_reg)
                begin
                    if (!found_reg || (p4_gd_reg < best_gd_reg))
                    begin
                        found_next   = 1'b1;
                        best_gd_next = p4_gd_reg;
                        best_pd_next = pd;
                    end
                    else if ((p4_gd_reg == best_gd_reg) && (pd < best_pd_reg))
                    begin
                        best_pd_next = pd;
                    end
                end
                if ((idx_reg == len_reg) && !p1_valid_reg && !p2_valid_reg &&
                    !p3_valid_reg && !p4_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_dist_next   = best_pd_reg;
                    out_status_next = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            len_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
        end
    end

    // Source cell: a table entry in partial mode, the query cell in full mode.
    assign src_x  = cfg.grid_kind ? rd_data[CELL_W-1:0] : qx_reg;
    assign src_y  = cfg.grid_kind ? rd_data[ENTRY_W-1:CELL_W] : qy_reg;
    assign px_ext = CTR_W'(cmd_reg.pos_x);
    assign py_ext = CTR_W'(cmd_reg.pos_y);

    // Payload registers and distance pipeline.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == S_CELL)
        begin
            qx_reg <= cell_of(cmd_reg.pos_x, g_eff);
            qy_reg <= cell_of(cmd_reg.pos_y, g_eff);
        end
        best_gd_reg    <= best_gd_next;
        best_pd_reg    <= best_pd_next;
        out_dist_reg   <= out_dist_next;
        out_status_reg <= out_status_next;

        // Centre positions and cell offsets.
        p2_ctr_x_reg <= CTR_W'(src_x) * CTR_W'(cfg.cell_size) +
                        CTR_W'(cfg.cell_size[CS_W-1:1]);
        p2_ctr_y_reg <= CTR_W'(src_y) * CTR_W'(cfg.cell_size) +
                        CTR_W'(cfg.cell_size[CS_W-1:1]);
        p2_gx_reg    <= (qx_reg >= src_x) ? qx_reg - src_x : src_x - qx_reg;
        p2_gy_reg    <= (qy_reg >= src_y) ? qy_reg - src_y : src_y - qy_reg;

        // Absolute offsets and grid distance.
        p3_dx_reg <= (px_ext >= p2_ctr_x_reg) ? px_ext - p2_ctr_x_reg
                                               : p2_ctr_x_reg - px_ext;
        p3_dy_reg <= (py_ext >= p2_ctr_y_reg) ? py_ext - p2_ctr_y_reg
                                               : p2_ctr_y_reg - py_ext;
        p3_gd_reg <= GD_W'(p2_gx_reg) * GD_W'(p2_gx_reg) +
                     GD_W'(p2_gy_reg) * GD_W'(p2_gy_reg);

        // Squares.
        p4_sx_reg <= SQ_W'(p3_dx_reg) * SQ_W'(p3_dx_reg);
        p4_sy_reg <= SQ_W'(p3_dy_reg) * SQ_W'(p3_dy_reg);
        p4_gd_reg <= p3_gd_reg;
    end

    assign out_valid  = out_valid_reg;
    assign out_dist   = out_dist_reg;
    assign out_status = out_status_reg;

    // The table never holds more than its capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("centre count exceeds table capacity");

    // Distance pipeline only runs during a scan.
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        p4_valid_reg |-> (state_reg == S_SCAN))
        else $error("pipeline active outside a scan");

    // A command is taken only when the result slot is free.
    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !out_valid_reg)
        else $error("command popped while a result is pending");

    // Scan never issues past its length.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg <= len_reg))
        else $error("scan index past its length");

endmodule

@@ design/grid_nearest_centre_distance.sv @@
// ----------------------------------------------------------------------------
// grid_nearest_centre_distance
// Squared distance from a query point to its own grid cell centre, or to the
// nearest loaded centre cell, with a loadable centre table.
// ----------------------------------------------------------------------------
// Items enter through a two-entry queue, so the input keeps accepting while a
// result waits. Commands then execute one at a time. In a partial-mode query
// the centre table RAM delivers one entry per cycle into a four-stage distance
// pipeline. A stalled output holds the back end until the result is accepted.
// No clearing pass is needed after reset.
module grid_nearest_centre_distance
    import gncd_pkg::*;
#(
    parameter int MAX_CENTRES = MAX_CENTRES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: opcode, pos_x, pos_y, centre_x, centre_y.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: distance_sq, zero fill.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Fields from bit 0: status.
    output logic [1:0]             m_tuser,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic [1:0] REG_KIND  = 2'd0;
    localparam logic [1:0] REG_CELLS = 2'd1;
    localparam logic [1:0] REG_SIZE  = 2'd2;

    cfg_t              cfg_reg;
    logic              cfg_wr;
    logic              q_full, q_push, q_pop, q_empty;
    cmd_t              push_cmd, pop_cmd;
    logic [DIST_W-1:0] out_dist;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_kind  <= 1'b0;
            cfg_reg.grid_cells <= CELL_W'(4);
            cfg_reg.cell_size  <= CS_W'(16384);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_KIND:  cfg_reg.grid_kind  <= pwdata[0];
                REG_CELLS: cfg_reg.grid_cells <= pwdata[CELL_W-1:0];
                REG_SIZE:  cfg_reg.cell_size  <= pwdata[CS_W-1:0];
                default:   cfg_reg.grid_kind  <= cfg_reg.grid_kind;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_KIND:  prdata = 32'(cfg_reg.grid_kind);
            REG_CELLS: prdata = 32'(cfg_reg.grid_cells);
            REG_SIZE:  prdata = 32'(cfg_reg.cell_size);
            default:   prdata = '0;
        endcase
    end

    gncd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    gncd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    gncd_back #(
        .MAX_CENTRES (MAX_CENTRES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_dist   (out_dist),
        .out_status (m_tuser)
    );

    assign m_tdata = OUT_TDATA_W'(out_dist);

endmodule

@@ tb/tb_grid_nearest_centre_distance.sv @@
// ----------------------------------------------------------------------------
// tb_grid_nearest_centre_distance
// Drives queries, centre loads and table clears into the grid nearest centre
// distance block under several grid settings. A behavioral copy of the block
// predicts each result, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_grid_nearest_centre_distance;
    import gncd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CENTRES = MAX_CENTRES_DEF;
    localparam int DRAIN_CYCLES = 400;
    localparam logic [3:0] ADDR_KIND = 4'd0;
    localparam logic [3:0] ADDR_CELLS = 4'd4;
    localparam logic [3:0] ADDR_SIZE = 4'd8;
    localparam logic [33:0] DIST_SAT = {34{1'b1}};

    typedef struct packed {
        logic [DIST_W-1:0] distance_sq;
        logic [1:0]        status;
    } answer_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [3:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    // Shadow copy of the block state and registers.
    logic              shadow_kind;
    logic [CELL_W-1:0] shadow_cells;
    logic [CS_W-1:0]   shadow_size;
    logic [ENTRY_W-1:0] shadow_table [NUM_CENTRES];
    int                shadow_count;

    answer_t pending_answers[$];
    int      mismatch_count;
    int      answer_count;
    int      query_count;
    int      load_count;
    bit      quiet_sender;
    bit      quiet_receiver;

    grid_nearest_centre_distance uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        #200ms;
        $display("CHECKS FAILED");
        $display("Run timed out.");
        $finish;
    end

    // Effective grid size after clamping.
    function automatic int grid_size();
        int g;
        g = shadow_cells;
        if (g == 0) g = 1;
        if (g > MAX_GRID_CELLS) g = MAX_GRID_CELLS;
        return g;
    endfunction

    // Cell index of one coordinate.
    function automatic longint cell_index(longint p, int g);
        longint c;
        c = (p * g) >>> POS_BITS;
        if (c > g - 1) c = g - 1;
        return c;
    endfunction

    // Saturated squared distance from a point to the centre of a cell.
    function automatic logic [DIST_W-1:0] centre_distance(longint px, longint py,
                                                          longint cx, longint cy);
        longint ox;
        longint oy;
        longint dx;
        longint dy;
        longint d;
        ox = cx * shadow_size + (shadow_size >> 1);
        oy = cy * shadow_size + (shadow_size >> 1);
        dx = px > ox ? px - ox : ox - px;
        dy = py > oy ? py - oy : oy - py;
        d = dx * dx + dy * dy;
        if (d > longint'(DIST_SAT)) d = longint'(DIST_SAT);
        return d[DIST_W-1:0];
    endfunction

    // Updates the shadow state for one item and queues any answer it gives.
    task automatic predict_answer(input cmd_t c);
        answer_t a;
        int g;
        longint qx;
        longint qy;
        longint cx;
        longint cy;
        longint gd;
        longint best_gd;
        logic [DIST_W-1:0] pd;
        logic [DIST_W-1:0] best_pd;
        a = '0;
        case (c.opcode)
            OP_LOAD:
            begin
                load_count++;
                if (shadow_count >= NUM_CENTRES)
                    a.status = ST_DROP;
                else
                begin
                    shadow_table[shadow_count] = {c.centre_y, c.centre_x};
                    shadow_count++;
                end
                pending_answers.push_back(a);
            end
            OP_CLEAR: shadow_count = 0;
            OP_QUERY:
            begin
                query_count++;
                g = grid_size();
                qx = cell_index(c.pos_x, g);
                qy = cell_index(c.pos_y, g);
                if (shadow_kind == 1'b0)
                    a.distance_sq = centre_distance(c.pos_x, c.pos_y, qx, qy);
                else if (shadow_count == 0)
                    a.status = ST_EMPTY;
                else
                begin
                    best_gd = -1;
                    best_pd = '0;
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        cx = shadow_table[i][CELL_W-1:0];
                        cy = shadow_table[i][ENTRY_W-1:CELL_W];
                        gd = (qx - cx) * (qx - cx) + (qy - cy) * (qy - cy);
                        pd = centre_distance(c.pos_x, c.pos_y, cx, cy);
                        if (best_gd < 0 || gd < best_gd)
                        begin
                            best_gd = gd;
                            best_pd = pd;
                        end
                        else if (gd == best_gd && pd < best_pd)
                            best_pd = pd;
                    end
                    a.distance_sq = best_pd;
                end
                pending_answers.push_back(a);
            end
            default: ;
        endcase
    endtask

    // Sends one item, with random idle cycles before it. The valid stays high
    // after the handshake so a following item goes out back to back.
    task automatic send_item(input cmd_t c);
        while (!quiet_sender && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'({c.centre_y, c.centre_x, c.pos_y, c.pos_x, c.opcode});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_answer(c);
    endtask

    // Writes one register over the configuration port, then idles.
    task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_KIND: shadow_kind = value[0];
            ADDR_CELLS: shadow_cells = value[CELL_W-1:0];
            ADDR_SIZE: shadow_size = value[CS_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Waits for all answers, then a pause so a trailing clear settles.
    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sets the grid registers; the cell size is given by the caller and need not follow 65536 / cells.
    task automatic set_grid(input logic kind, input int cells, input int size);
        drain();
        write_reg(ADDR_KIND, 32'(kind));
        write_reg(ADDR_CELLS, 32'(cells));
        write_reg(ADDR_SIZE, 32'(size));
    endtask

    function automatic cmd_t make_cmd(input logic [1:0] op, input int px, input int py,
                                      input int cx, input int cy);
        cmd_t c;
        c.opcode = op;
        c.pos_x = px[POS_BITS-1:0];
        c.pos_y = py[POS_BITS-1:0];
        c.centre_x = cx[CELL_W-1:0];
        c.centre_y = cy[CELL_W-1:0];
        return c;
    endfunction

    function automatic cmd_t random_query();
        return make_cmd(OP_QUERY, $urandom_range(65535), $urandom_range(65535), 0, 0);
    endfunction

    // Centre cells mostly inside the grid, sometimes anywhere in 7 bits.
    function automatic cmd_t random_load();
        int g;
        g = grid_size();
        if ($urandom_range(9) == 0)
            return make_cmd(OP_LOAD, $urandom, $urandom, $urandom_range(127),
                            $urandom_range(127));
        return make_cmd(OP_LOAD, $urandom, $urandom, $urandom_range(g - 1),
                        $urandom_range(g - 1));
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            answer_count++;
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: distance %0d status %0d",
                             m_tdata[DIST_W-1:0], m_tuser);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_tdata[DIST_W-1:0] !== want.distance_sq || m_tuser !== want.status
                    || m_tdata[OUT_TDATA_W-1:DIST_W] !== '0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected distance %0d status %0d, got %0d status %0d",
                                 want.distance_sq, want.status, m_tdata, m_tuser);
                end
            end
        end
    end

    // Receiver stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= quiet_receiver || ($urandom_range(99) >= 21);
    end

    // Full mode: extremes of position and grid size.
    task automatic test_full_mode();
        set_grid(1'b0, 4, 16384);
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 0));
        send_item(make_cmd(OP_QUERY, 65535, 65535, 0, 0));
        send_item(make_cmd(OP_QUERY, 16383, 16384, 0, 0));
        set_grid(1'b0, 0, 1);
        send_item(make_cmd(OP_QUERY, 65535, 0, 0, 0));
        set_grid(1'b0, 127, 65536);
        send_item(make_cmd(OP_QUERY, 65535, 65535, 0, 0));
        send_item(make_cmd(OP_QUERY, 0, 65535, 0, 0));
        send_item(make_cmd(OP_NONE, 123, 456, 7, 8));
    endtask

    // Partial mode: empty table, outside centres, clear.
    task automatic test_partial_directed();
        set_grid(1'b1, 65, 1008);
        send_item(make_cmd(OP_QUERY, 100, 100, 0, 0));
        send_item(make_cmd(OP_LOAD, 0, 0, 0, 0));
        send_item(make_cmd(OP_LOAD, 0, 0, 2, 0));
        send_item(make_cmd(OP_LOAD, 0, 0, 127, 127));
        send_item(make_cmd(OP_QUERY, 1008, 0, 0, 0));
        send_item(make_cmd(OP_QUERY, 65535, 65535, 0, 0));
        send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 0));
        set_grid(1'b1, 1, 65536);
        send_item(make_cmd(OP_LOAD, 0, 0, 64, 64));
        send_item(make_cmd(OP_QUERY, 65535, 0, 0, 0));
        send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0));
    endtask

    // Fills the table past capacity so loads are dropped, then queries it.
    task automatic test_table_full();
        set_grid(1'b1, 16, 4096);
        quiet_sender = 1'b1;
        quiet_receiver = 1'b1;
        for (int i = 0; i < NUM_CENTRES + 3; i++)
            send_item(random_load());
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        for (int i = 0; i < 6; i++)
            send_item(random_query());
        send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0));
    endtask

    // Random phases: small tables with many queries, occasional noise.
    task automatic test_random();
        int settings [6][3] = '{'{1, 4, 16384}, '{1, 65, 1008}, '{0, 37, 1771},
                                '{1, 2, 32768}, '{1, 127, 65535}, '{0, 100, 1}};
        int r;
        for (int p = 0; p < 6; p++)
        begin
            set_grid(settings[p][0] != 0, settings[p][1], settings[p][2]);
            quiet_sender = (p == 3);
            quiet_receiver = (p == 3);
            for (int n = 0; n < 235; n++)
            begin
                r = $urandom_range(99);
                if (r < 60)
                    send_item(random_query());
                else if (r < 92)
                    send_item(random_load());
                else if (r < 97)
                    send_item(make_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
                else
                    send_item(make_cmd(OP_NONE, $urandom, $urandom, $urandom, $urandom));
            end
            send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0));
        end
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        shadow_kind = 1'b0;
        shadow_cells = CELL_W'(4);
        shadow_size = CS_W'(16384);
        shadow_count = 0;
        mismatch_count = 0;
        answer_count = 0;
        query_count = 0;
        load_count = 0;
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_mode();
        test_partial_directed();
        test_table_full();
        test_random();
        drain();

        if (pending_answers.size() != 0)
        begin
            mismatch_count += pending_answers.size();
            $display("%0d results never arrived.", pending_answers.size());
        end
        $display("Covered %0d queries and %0d centre loads, %0d results compared.",
                 query_count, load_count, answer_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
